@@ design/exponential_search_engine_macros.svh @@
// Assertion macros for the exponential search engine.
// Used by design files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef EXPONENTIAL_SEARCH_ENGINE_MACROS_SVH
`define EXPONENTIAL_SEARCH_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define ESE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ese check failed");
`define ESE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ese check failed");
`else
`define ESE_ASSERT_IMPL(label, ante, cons)
`define ESE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/ese_pkg.sv @@
// Shared widths, codes and interface structs for the exponential search engine.
// No dependencies.
package ese_pkg;

	localparam int KEY_W = 32;
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef struct packed {
		logic                    start;
		logic signed [KEY_W-1:0] key;
	} ese_req_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_index;
	} ese_res_t;

endpackage

@@ design/ese_store.sv @@
// Sorted value store: one write port, one read port with registered read data.
// Depends on ese_pkg.
module ese_store #(
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [ese_pkg::KEY_W-1:0] wdata,
	input  logic [AW-1:0]                    raddr,
	output logic signed [ese_pkg::KEY_W-1:0] rdata
);

	logic signed [ese_pkg::KEY_W-1:0] mem [0:DEPTH-1];
	logic signed [ese_pkg::KEY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/ese_ctrl.sv @@
// Search sequencer: entry 0 probe, doubling phase, then bisection, with one shared comparator.
// Depends on ese_pkg and exponential_search_engine_macros.svh; reads through ese_store.
`include "exponential_search_engine_macros.svh"
module ese_ctrl #(
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int IW = ((AW > ese_pkg::CNT_W) ? AW : ese_pkg::CNT_W) + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ese_pkg::ese_req_t                req,
	input  logic [IW-1:0]                    n,
	input  logic signed [ese_pkg::KEY_W-1:0] rdata,
	output logic [AW-1:0]                    raddr,
	output logic                             busy,
	output logic                             res_valid,
	input  logic                             res_take,
	output ese_pkg::ese_res_t                res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_W0   = 4'd1;
	localparam logic [3:0] S_C0   = 4'd2;
	localparam logic [3:0] S_WD   = 4'd3;
	localparam logic [3:0] S_CD   = 4'd4;
	localparam logic [3:0] S_BS   = 4'd5;
	localparam logic [3:0] S_BM   = 4'd6;
	localparam logic [3:0] S_WB   = 4'd7;
	localparam logic [3:0] S_CB   = 4'd8;
	localparam logic [3:0] S_RES  = 4'd9;

	logic [3:0]                       state_q;
	logic signed [ese_pkg::KEY_W-1:0] key_q;
	logic [IW-1:0]                    n_q;
	logic [IW-1:0]                    idx_q;
	logic [IW-1:0]                    lo_q;
	logic [IW-1:0]                    hi_q;
	ese_pkg::ese_res_t                res_q;

	logic          eq;
	logic          le;
	logic [IW-1:0] idx_dbl;
	logic [IW-1:0] n_m1;
	logic [IW:0]   mid_sum;
	logic [IW-1:0] mid;

	// shared comparator
	assign eq = (rdata == key_q);
	assign le = (rdata <= key_q);

	assign idx_dbl = {idx_q[IW-2:0], 1'b0};
	assign n_m1    = n_q - IW'(1);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IW:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						state_q <= (n == '0) ? S_RES : S_W0;
					end
				end
				S_W0: state_q <= S_C0;
				S_C0: begin
					if (eq) begin
						state_q <= S_RES;
					end else begin
						state_q <= (IW'(1) < n_q) ? S_WD : S_BS;
					end
				end
				S_WD: state_q <= S_CD;
				S_CD: begin
					if (le && (idx_dbl < n_q)) begin
						state_q <= S_WD;
					end else begin
						state_q <= S_BS;
					end
				end
				S_BS: state_q <= S_BM;
				S_BM: state_q <= S_WB;
				S_WB: state_q <= S_CB;
				S_CB: begin
					if (eq) begin
						state_q <= S_RES;
					end else if (le) begin
						state_q <= (idx_q == hi_q) ? S_RES : S_BM;
					end else begin
						state_q <= (idx_q == lo_q) ? S_RES : S_BM;
					end
				end
				S_RES: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.start) begin
					key_q <= req.key;
					n_q   <= n;
					idx_q <= '0;
					res_q <= '0;
				end
			end
			S_C0: begin
				if (eq) begin
					res_q.found       <= 1'b1;
					res_q.match_index <= '0;
				end else begin
					idx_q <= IW'(1);
				end
			end
			S_CD: begin
				if (le) begin
					idx_q <= idx_dbl;
				end
			end
			S_BS: begin
				lo_q <= idx_q >> 1;
				hi_q <= (idx_q < n_m1) ? idx_q : n_m1;
			end
			S_BM: idx_q <= mid;
			S_CB: begin
				if (eq) begin
					res_q.found       <= 1'b1;
					res_q.match_index <= idx_q[ese_pkg::IDX_W-1:0];
				end else if (le) begin
					lo_q <= idx_q + IW'(1);
				end else begin
					hi_q <= idx_q - IW'(1);
				end
			end
			default: ;
		endcase
	end

	assign raddr     = idx_q[AW-1:0];
	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_RES);
	assign res       = res_q;

	`ESE_ASSERT_IMPL(a_start_idle, req.start, state_q == S_IDLE)
	`ESE_ASSERT_IMPL(a_probe_in_count, state_q == S_WD, idx_q < n_q)
	`ESE_ASSERT_IMPL(a_range_ordered, state_q == S_CB, lo_q <= hi_q)
	`ESE_ASSERT_IMPL(a_mid_in_range, state_q == S_CB, idx_q >= lo_q && idx_q <= hi_q)
	`ESE_ASSERT_NEXT(a_res_hold, state_q == S_RES && !res_take, state_q == S_RES && $stable(res_q))

endmodule

@@ design/exponential_search_engine.sv @@
// Write item: taken with no result. Search item: an entry 0 probe, then D doubling probes and
// B bisection probes before the result; a hit on entry 0 or an empty count returns sooner.
// One item at a time: the next transfer is taken once the result leaves the sequencer.
// Reset clears the entry count and all handshake state; store contents are undefined until written.
// Depends on ese_pkg, ese_store, ese_ctrl.
module exponential_search_engine #(
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ese_pkg::CNT_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [ese_pkg::IDX_W-1:0]        write_index,
	input  logic signed [ese_pkg::KEY_W-1:0] item_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             found,
	output logic [ese_pkg::IDX_W-1:0]        match_index
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = ((AW > ese_pkg::CNT_W) ? AW : ese_pkg::CNT_W) + 1;
	localparam logic [IW-1:0] DEPTH_W = IW'(DEPTH);

	logic [ese_pkg::CNT_W-1:0]        entry_count_q;
	logic                             out_valid_q;
	ese_pkg::ese_res_t                out_res_q;

	logic                             in_xfer;
	logic [IW-1:0]                    count_ext;
	logic [IW-1:0]                    n_sat;
	logic [IW-1:0]                    widx_ext;
	logic                             we;
	logic [AW-1:0]                    raddr;
	logic signed [ese_pkg::KEY_W-1:0] rdata;
	logic                             busy;
	logic                             res_valid;
	logic                             res_take;
	ese_pkg::ese_req_t                req;
	ese_pkg::ese_res_t                res;

	assign in_stall  = busy;
	assign in_xfer   = in_valid && !in_stall;
	assign count_ext = IW'(entry_count_q);
	assign n_sat     = (count_ext > DEPTH_W) ? DEPTH_W : count_ext;
	assign widx_ext  = IW'(write_index);
	assign we        = in_xfer && (kind == ese_pkg::KIND_WRITE) && (widx_ext < DEPTH_W);

	assign req.start = in_xfer && (kind == ese_pkg::KIND_SEARCH);
	assign req.key   = item_value;

	assign res_take  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_res_q <= res;
		end
	end

	ese_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (widx_ext[AW-1:0]),
		.wdata (item_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	ese_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.n         (n_sat),
		.rdata     (rdata),
		.raddr     (raddr),
		.busy      (busy),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign out_valid   = out_valid_q;
	assign found       = out_res_q.found;
	assign match_index = out_res_q.match_index;

endmodule
